[design/mrpt_pkg.sv]
// Package: shared constants, types and the base table for the prime tester.
package mrpt_pkg;

    localparam int NUMBER_WIDTH_DEF = 63;
    localparam int BASE_COUNT_DEF   = 19;
    localparam int BASE_IDX_W       = 5;
    localparam int QUEUE_DEPTH      = 2;

    // classification handed from front to back
    typedef enum logic [1:0] {
        CLS_PRIME     = 2'd0,
        CLS_COMPOSITE = 2'd1,
        CLS_TEST      = 2'd2
    } cls_t;

    // small prime bases, seven bits each
    function automatic logic [6:0] base_at(input logic [BASE_IDX_W-1:0] idx);
        logic [6:0] v;
        case (idx)
            5'd0:  v = 7'd2;
            5'd1:  v = 7'd3;
            5'd2:  v = 7'd5;
            5'd3:  v = 7'd7;
            5'd4:  v = 7'd11;
            5'd5:  v = 7'd13;
            5'd6:  v = 7'd17;
            5'd7:  v = 7'd19;
            5'd8:  v = 7'd23;
            5'd9:  v = 7'd29;
            5'd10: v = 7'd31;
            5'd11: v = 7'd37;
            5'd12: v = 7'd41;
            5'd13: v = 7'd43;
            5'd14: v = 7'd47;
            5'd15: v = 7'd53;
            5'd16: v = 7'd59;
            5'd17: v = 7'd61;
            5'd18: v = 7'd67;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

[design/mrpt_front.sv]
// Front end: accepts candidates, classifies them and pushes them into a short queue.
module mrpt_front #(
    parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEF,
    parameter int BASE_COUNT   = mrpt_pkg::BASE_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NUMBER_WIDTH-1:0] in_num,
    output logic                    q_valid,
    input  logic                    q_pop,
    output logic [NUMBER_WIDTH-1:0] q_num,
    output mrpt_pkg::cls_t          q_cls
);

    localparam int QD = mrpt_pkg::QUEUE_DEPTH;

    logic [NUMBER_WIDTH-1:0] num_reg [QD];
    mrpt_pkg::cls_t          cls_reg [QD];
    logic                    rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    is_base;
    mrpt_pkg::cls_t          cls_in;
    logic                    push;

    // base match over the configured bases (independent compares)
    always_comb
    begin
        is_base = 1'b0;
        for (int i = 0; i < BASE_COUNT; i++)
        begin
            if (in_num == NUMBER_WIDTH'(mrpt_pkg::base_at(mrpt_pkg::BASE_IDX_W'(i))))
                is_base = 1'b1;
        end
        if (is_base)
            cls_in = mrpt_pkg::CLS_PRIME;
        else if (!in_num[0] || in_num == NUMBER_WIDTH'(1))
            cls_in = mrpt_pkg::CLS_COMPOSITE;
        else
            cls_in = mrpt_pkg::CLS_TEST;
    end

    assign in_stall = (cnt_reg == 2'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_num    = num_reg[rd_reg];
    assign q_cls    = cls_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ (q_pop && q_valid);
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            num_reg[wr_reg] <= in_num;
            cls_reg[wr_reg] <= cls_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QD)) |-> in_stall) else $error("full queue not stalling");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("push lost");

endmodule

[design/mrpt_back.sv]
// Back end: runs the strong-probable-prime rounds with a bit-serial modular multiplier.
module mrpt_back #(
    parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEF,
    parameter int BASE_COUNT   = mrpt_pkg::BASE_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  logic [NUMBER_WIDTH-1:0] q_num,
    input  mrpt_pkg::cls_t          q_cls,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_prime
);

    localparam int W  = NUMBER_WIDTH;
    localparam int SW = $clog2(W + 1);
    localparam int BW = mrpt_pkg::BASE_IDX_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_INIT  = 8'b0000_0010,
        ST_BASE  = 8'b0000_0100,
        ST_PSTEP = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_SQ    = 8'b0100_0000,
        ST_NEXT  = 8'b1000_0000
    } state_t;

    // what the multiplier result feeds into
    typedef enum logic [1:0] {
        M_R   = 2'd0,
        M_B   = 2'd1,
        M_X   = 2'd2
    } mdst_t;

    state_t          st_reg, st_next;
    logic [W-1:0]    n_reg, d_reg, e_reg, r_reg, b_reg;
    logic [W-1:0]    ma_reg, mb_reg, acc_reg;
    logic [SW-1:0]   s_reg, i_reg, bit_reg;
    logic [BW-1:0]   base_reg;
    logic            ok_reg, res_reg, ov_reg;
    mdst_t           dst_reg;
    logic [W:0]      dbl, dbl_red, sum, sum_red;
    logic [W-1:0]    nm1;
    logic            round_done, round_pass, more_sq;

    assign nm1       = n_reg - W'(1);
    assign out_valid = ov_reg;
    assign is_prime  = res_reg;
    assign q_pop     = (st_reg == ST_IDLE) && q_valid && !ov_reg;

    // one shift-add step of r = a*b mod n
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
        sum     = dbl_red + {1'b0, ma_reg};
        if (!mb_reg[bit_reg[SW-1:0]])
            sum = dbl_red;
        sum_red = (sum >= {1'b0, n_reg}) ? sum - {1'b0, n_reg} : sum;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (q_pop) st_next = (q_cls == mrpt_pkg::CLS_TEST) ? ST_INIT : ST_IDLE;
            ST_INIT:  if (d_reg[0]) st_next = ST_BASE;
            ST_BASE:  st_next = ST_PSTEP;
            ST_PSTEP:
            begin
                // a base above the candidate is brought below it first
                if (b_reg < n_reg)
                    st_next = (e_reg == '0) ? ST_CHECK : ST_MUL;
            end
            ST_MUL:   if (bit_reg == '0) st_next = (dst_reg == M_X) ? ST_SQ : ST_PSTEP;
            ST_CHECK: st_next = ST_SQ;
            ST_SQ:    st_next = ST_NEXT;
            ST_NEXT:  st_next = ST_BASE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                n_reg <= q_num;
                d_reg <= q_num - W'(1);
                s_reg <= '0;
            end
            ST_INIT:
            begin
                if (!d_reg[0])
                begin
                    d_reg <= d_reg >> 1;
                    s_reg <= s_reg + SW'(1);
                end
            end
            ST_BASE:
            begin
                e_reg <= d_reg;
                r_reg <= W'(1);
                b_reg <= W'(mrpt_pkg::base_at(base_reg));
                i_reg <= SW'(1);
            end
            ST_PSTEP:
            begin
                // reduce the base, then r*b when low exponent bit set, else b*b
                if (b_reg >= n_reg)
                    b_reg <= b_reg - n_reg;
                else if (e_reg != '0)
                begin
                    acc_reg <= '0;
                    bit_reg <= SW'(W - 1);
                    if (e_reg[0])
                    begin
                        ma_reg  <= r_reg;
                        mb_reg  <= b_reg;
                        dst_reg <= M_R;
                    end
                    else
                    begin
                        ma_reg  <= b_reg;
                        mb_reg  <= b_reg;
                        dst_reg <= M_B;
                    end
                end
            end
            ST_MUL:
            begin
                acc_reg <= sum_red[W-1:0];
                if (bit_reg != '0)
                    bit_reg <= bit_reg - SW'(1);
                else
                begin
                    case (dst_reg)
                        M_R:
                        begin
                            r_reg <= sum_red[W-1:0];
                            e_reg <= e_reg & ~W'(1);
                        end
                        M_B:
                        begin
                            b_reg <= sum_red[W-1:0];
                            e_reg <= e_reg >> 1;
                        end
                        default: r_reg <= sum_red[W-1:0];
                    endcase
                end
            end
            ST_SQ:
            begin
                // launch of a squaring x*x
                if (more_sq)
                begin
                    ma_reg  <= r_reg;
                    mb_reg  <= r_reg;
                    dst_reg <= M_X;
                    bit_reg <= SW'(W - 1);
                    acc_reg <= '0;
                    i_reg   <= i_reg + SW'(1);
                end
            end
            default: ;
        endcase
    end

    // round decision
    always_comb
    begin
        round_done = 1'b0;
        round_pass = 1'b0;
        more_sq    = 1'b0;
        if (st_reg == ST_SQ)
        begin
            if (i_reg == SW'(1) && (r_reg == W'(1) || r_reg == nm1))
            begin
                round_done = 1'b1;
                round_pass = 1'b1;
            end
            else if (i_reg != SW'(1) && r_reg == nm1)
            begin
                round_done = 1'b1;
                round_pass = 1'b1;
            end
            else if (i_reg != SW'(1) && r_reg == W'(1))
                round_done = 1'b1;
            else if (i_reg >= s_reg)
                round_done = 1'b1;
            else
                more_sq = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            res_reg  <= 1'b0;
            ok_reg   <= 1'b1;
            base_reg <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (st_reg == ST_IDLE && q_pop)
            begin
                base_reg <= '0;
                ok_reg   <= 1'b1;
                if (q_cls != mrpt_pkg::CLS_TEST)
                begin
                    ov_reg  <= 1'b1;
                    res_reg <= (q_cls == mrpt_pkg::CLS_PRIME);
                end
            end
            if (more_sq)
                st_reg <= ST_MUL;
            else if (round_done)
            begin
                if (base_reg == BW'(BASE_COUNT - 1))
                begin
                    st_reg  <= ST_IDLE;
                    ov_reg  <= 1'b1;
                    res_reg <= ok_reg && round_pass;
                end
                else
                begin
                    st_reg   <= ST_BASE;
                    base_reg <= base_reg + BW'(1);
                    ok_reg   <= ok_reg && round_pass;
                end
            end
            else if (st_reg != ST_SQ)
                st_reg <= st_next;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (st_reg == ST_IDLE)) else $error("pop while busy");
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_reg))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(is_prime)))
        else $error("result dropped");

endmodule

[design/miller_rabin_prime_tester.sv]
// Top level: deterministic Miller-Rabin prime tester with decoupled front and back.
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_stall   | candidate[NUMBER_WIDTH-1:0]
//  out     | out | out_valid / out_stall | is_prime
// Trivial candidates (bases, even, one) are answered at the pop without any rounds.
// Tested candidates run all BASE_COUNT rounds, with a subtraction step when a base
// exceeds the candidate; their run time is dominated by the one-bit-per-cycle
// shift-add modular multiplier in the back end.
// Reset clears queue pointers, sequencer state and the result valid.
// A stalled result holds the back end; the two-entry queue keeps taking beats until it is full.
module miller_rabin_prime_tester #(
    parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEF,
    parameter int BASE_COUNT   = mrpt_pkg::BASE_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NUMBER_WIDTH-1:0] candidate,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_prime
);

    logic                    q_valid, q_pop;
    logic [NUMBER_WIDTH-1:0] q_num;
    mrpt_pkg::cls_t          q_cls;

    mrpt_front #(.NUMBER_WIDTH(NUMBER_WIDTH), .BASE_COUNT(BASE_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_num(candidate), .q_valid(q_valid), .q_pop(q_pop), .q_num(q_num), .q_cls(q_cls)
    );

    mrpt_back #(.NUMBER_WIDTH(NUMBER_WIDTH), .BASE_COUNT(BASE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_num(q_num),
        .q_cls(q_cls), .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
    );

endmodule

[test/mrpt_checker.sv]
`timescale 1ns / 100ps
// Checker: watches both channels, predicts primality and compares each result beat.
module mrpt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [62:0] candidate,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        is_prime,
    output int          errors,
    output int          pending
);

    bit verdict_q[$];

    // modular product through a double-width intermediate
    function automatic logic [62:0] mul_mod(input logic [62:0] a, input logic [62:0] b,
                                            input logic [62:0] m);
        logic [125:0] p;
        p = {63'd0, a} * {63'd0, b};
        return 63'(p % {63'd0, m});
    endfunction

    function automatic logic [62:0] pow_mod(input logic [62:0] b, input logic [62:0] e,
                                            input logic [62:0] m);
        logic [62:0] r;
        logic [62:0] x;
        logic [62:0] k;
        r = 63'd1 % m;
        x = b % m;
        k = e;
        while (k != 0)
        begin
            if (k[0])
                r = mul_mod(r, x, m);
            k = k >> 1;
            x = mul_mod(x, x, m);
        end
        return r;
    endfunction

    // one strong-probable-prime round, n odd and at least 3
    function automatic bit passes_round(input logic [62:0] n, input logic [62:0] a);
        logic [62:0] d;
        logic [62:0] x;
        int s;
        d = n - 1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        x = pow_mod(a, d, n);
        if (x == 1 || x == n - 1)
            return 1'b1;
        for (int i = 1; i < s; i++)
        begin
            x = mul_mod(x, x, n);
            if (x == n - 1)
                return 1'b1;
            if (x == 1)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic bit primality(input logic [62:0] n);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < mrpt_pkg::BASE_COUNT_DEF; i++)
            if (n == 63'(mrpt_pkg::base_at(5'(i))))
                return 1'b1;
        if (n < 3 || !n[0])
            return 1'b0;
        for (int i = 0; i < mrpt_pkg::BASE_COUNT_DEF; i++)
            if (!passes_round(n, 63'(mrpt_pkg::base_at(5'(i)))))
                ok = 1'b0;
        return ok;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // predict on input beats, compare on result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                verdict_q.insert(verdict_q.size(), primality(candidate));
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("is_prime beat with nothing expected, actual %0d", is_prime);
                    errors++;
                end
                else if (verdict_q[0] !== is_prime)
                begin
                    $error("is_prime expected %0d actual %0d", verdict_q[0], is_prime);
                    errors++;
                    void'(verdict_q.pop_front());
                end
                else
                    void'(verdict_q.pop_front());
            end
            pending = verdict_q.size();
        end
    end

endmodule

[test/tb_miller_rabin_prime_tester.sv]
`timescale 1ns / 100ps
// Testbench top: drives candidates and result stalls, gives the verdict.
module tb_miller_rabin_prime_tester;

    localparam int WATCHDOG_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [62:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic        is_prime;
    int          errors;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    int          large_left;

    miller_rabin_prime_tester uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
        .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
    );

    mrpt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
        .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall, rerolled every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one candidate beat, entered and left at a falling edge
    task automatic offer(input logic [62:0] n);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [62:0] wide_random();
        return 63'({$urandom(), $urandom()});
    endfunction

    // mostly cheap or small candidates; odd wide ones are rationed
    function automatic logic [62:0] pick_candidate();
        int kind;
        int bits;
        logic [62:0] v;
        kind = $urandom_range(99);
        if (kind < 30)
            v = wide_random() & ~63'd1;
        else if (kind < 40)
            v = 63'(mrpt_pkg::base_at(5'($urandom_range(18))));
        else if (kind < 45)
            v = 63'($urandom_range(1));
        else if (kind < 52 && large_left > 0)
        begin
            large_left--;
            v = wide_random() | 63'd1;
        end
        else
        begin
            bits = $urandom_range(12, 3);
            v = (63'($urandom()) & ((63'd1 << bits) - 1)) | 63'd1;
            if (v < 3)
                v = 63'd3;
        end
        return v;
    endfunction

    initial
    begin
        logic [62:0] directed [$];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        candidate    = '0;
        out_stall    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        large_left   = 4;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero, one, bases, evens, width extremes, pseudoprimes, squaring limit
        directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd67, 63'd69, 63'd71,
                     63'd9, 63'd25, 63'd561, 63'd2047, 63'd3215031751,
                     63'd4294967297, 63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF,
                     63'd9223372036854775783, 63'd2305843009213693951};
        foreach (directed[i])
            offer(directed[i]);

        // random part in idle and stall phases
        for (int i = 0; i < 100; i++)
        begin
            case (i / 25)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            offer(pick_candidate());
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/mrpt_pkg.sv
design/mrpt_front.sv
design/mrpt_back.sv
design/miller_rabin_prime_tester.sv
test/mrpt_checker.sv
test/tb_miller_rabin_prime_tester.sv
